/* rtl/core/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: command and
// status codes, and the controller to datapath command and status bundles.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int PLE_CAPACITY = 64;
	// A dump never emits more results than this.
	localparam int MAX_RESULTS  = 64;

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_DUMP   = 3'd2,
		KIND_MOVE   = 3'd3,
		KIND_REV    = 3'd4,
		KIND_ROTL   = 3'd5,
		KIND_ROTR   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} stat_code_t;

	typedef enum logic [2:0] {
		AS_IDX, AS_IDX_M1, AS_IDX_P1, AS_POS, AS_COUNT, AS_COUNT_M1, AS_ONE, AS_ZERO
	} addr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD, IDX_POS, IDX_COUNT, IDX_ZERO, IDX_INC, IDX_DEC, IDX_REM
	} idx_op_t;

	typedef enum logic [2:0] {
		REM_HOLD, REM_LOAD, REM_SUB, REM_NEG, REM_DEC
	} rem_op_t;

	typedef enum logic [1:0] {
		VAL_ZERO, VAL_TAKE, VAL_RD
	} val_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_RESP,
		S_INS_CHK, S_INS_WR,
		S_REM_RD, S_REM_GET, S_REM_CHK, S_REM_WR, S_MV_SET,
		S_DUMP_RD, S_DUMP_OUT,
		S_ROT_MOD, S_ROT_ADJ, S_ROT_CHK, S_ROT_FULL, S_ROT_WR, S_ROT_HD
	} state_t;

	typedef struct packed {
		logic       load;
		addr_sel_t  addr_sel;
		logic       rd_en;
		logic       wr_en;
		logic       wr_from_rd;
		idx_op_t    idx_op;
		rem_op_t    rem_op;
		logic       take_cap;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       rev_flip;
		logic       head_ld;
		logic       mv_setup;
		logic       emit;
		stat_code_t emit_status;
		val_sel_t   emit_val;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       empty;
		logic       full;
		logic       pos_gt_n;
		logic       pos_ge_n;
		logic       tgt_ge_n;
		logic       idx_eq_pos;
		logic       idx_p1_lt_n;
		logic       dump_last;
		logic       rem_ge_n;
		logic       rem_zero;
		logic       out_free;
	} dp_stat_t;

endpackage

/* rtl/core/ple_dpath.sv */
// ----------------------------------------------------------------------------
// ple_dpath
// Datapath: list memory addressed as a circular buffer with a head pointer
// and a direction flag, the entry count, the work registers and the output
// register.
// ----------------------------------------------------------------------------
module ple_dpath #(
	parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::cmd_t     cmd,
	output ple_pkg::dp_stat_t stat,
	input  logic [55:0]       in_data,
	input  logic [2:0]        in_kind,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [39:0]       out_data,
	output logic              out_last
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > 7) ? CW : 7;
	localparam int AW = $clog2(CAPACITY);
	localparam int SW = LW + 2;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_data_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic          rev_q;
	logic [2:0]    kind_q;
	logic [31:0]   ins_val_q;
	logic [31:0]   take_val_q;
	logic [LW-1:0] pos_q, tgt_q, rem_q, idx_q;
	logic          out_valid_q;
	logic [31:0]   out_value_q;
	logic [1:0]    out_status_q;
	logic          out_last_q;

	logic [LW-1:0] count_x, lidx;
	logic [SW-1:0] sum;
	logic [AW-1:0] phys;
	logic [LW:0]   idx_p1;

	assign count_x = LW'(count_q);
	assign idx_p1  = {1'b0, idx_q} + (LW+1)'(1);

	// Logical position to physical slot; the reversed list runs downward.
	always_comb begin
		case (cmd.addr_sel)
			AS_IDX:      lidx = idx_q;
			AS_IDX_M1:   lidx = idx_q - LW'(1);
			AS_IDX_P1:   lidx = idx_p1[LW-1:0];
			AS_POS:      lidx = pos_q;
			AS_COUNT:    lidx = count_x;
			AS_COUNT_M1: lidx = count_x - LW'(1);
			AS_ONE:      lidx = LW'(1);
			default:     lidx = '0;
		endcase
		if (rev_q) begin
			sum = SW'(head_q) + SW'(CAPACITY) - SW'(lidx);
		end else begin
			sum = SW'(head_q) + SW'(lidx);
		end
		if (sum >= SW'(CAPACITY)) begin
			phys = AW'(sum - SW'(CAPACITY));
		end else begin
			phys = AW'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[phys] <= cmd.wr_from_rd ? rd_data_q : ins_val_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[phys];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_kind;
			ins_val_q <= in_data[31:0];
			pos_q     <= LW'(in_data[38:32]);
			tgt_q     <= LW'(in_data[45:39]);
		end
		if (cmd.mv_setup) begin
			pos_q     <= tgt_q;
			ins_val_q <= take_val_q;
		end
		if (cmd.take_cap) begin
			take_val_q <= rd_data_q;
		end
		case (cmd.idx_op)
			IDX_POS:   idx_q <= pos_q;
			IDX_COUNT: idx_q <= count_x;
			IDX_ZERO:  idx_q <= '0;
			IDX_INC:   idx_q <= idx_p1[LW-1:0];
			IDX_DEC:   idx_q <= idx_q - LW'(1);
			IDX_REM:   idx_q <= rem_q;
			default:   idx_q <= idx_q;
		endcase
		case (cmd.rem_op)
			REM_LOAD: rem_q <= LW'(in_data[52:46]);
			REM_SUB:  rem_q <= rem_q - count_x;
			REM_NEG:  rem_q <= count_x - rem_q;
			REM_DEC:  rem_q <= rem_q - LW'(1);
			default:  rem_q <= rem_q;
		endcase
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
			case (cmd.emit_val)
				VAL_TAKE: out_value_q <= take_val_q;
				VAL_RD:   out_value_q <= rd_data_q;
				default:  out_value_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.head_ld) begin
				head_q <= phys;
			end
			if (cmd.rev_flip) begin
				rev_q <= ~rev_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.kind        = kind_q;
		stat.empty       = (count_q == '0);
		stat.full        = (count_q == CW'(CAPACITY));
		stat.pos_gt_n    = (pos_q > count_x);
		stat.pos_ge_n    = (pos_q >= count_x);
		stat.tgt_ge_n    = (tgt_q >= count_x);
		stat.idx_eq_pos  = (idx_q == pos_q);
		stat.idx_p1_lt_n = (idx_p1 < {1'b0, count_x});
		stat.dump_last   = (idx_p1 == {1'b0, count_x})
			|| (idx_p1 == (LW+1)'(MAX_RESULTS));
		stat.rem_ge_n    = (rem_q >= count_x);
		stat.rem_zero    = (rem_q == '0);
		stat.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'd0, out_status_q, out_value_q};
	assign out_last  = out_last_q;

endmodule

/* rtl/core/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: decodes each command item and steps the datapath through the
// shifts, rotation steps and dump reads that it needs.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ple_pkg::dp_stat_t stat,
	output ple_pkg::cmd_t     cmd
);
	import ple_pkg::*;

	state_t     state_q, state_d;
	stat_code_t resp_code_q, resp_code_d;
	val_sel_t   resp_val_q, resp_val_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			resp_code_q <= STAT_OK;
			resp_val_q  <= VAL_ZERO;
		end else begin
			state_q     <= state_d;
			resp_code_q <= resp_code_d;
			resp_val_q  <= resp_val_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		resp_code_d = resp_code_q;
		resp_val_d  = resp_val_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.addr_sel    = AS_ZERO;
		cmd.idx_op      = IDX_HOLD;
		cmd.rem_op      = REM_HOLD;
		cmd.emit_status = STAT_OK;
		cmd.emit_val    = VAL_ZERO;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					cmd.rem_op = REM_LOAD;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				resp_code_d = STAT_OK;
				resp_val_d  = VAL_ZERO;
				state_d     = S_RESP;
				case (stat.kind)
					KIND_INSERT: begin
						if (stat.full) begin
							resp_code_d = STAT_FULL;
						end else if (stat.pos_gt_n) begin
							resp_code_d = STAT_RANGE;
						end else begin
							cmd.idx_op = IDX_COUNT;
							state_d    = S_INS_CHK;
						end
					end
					KIND_REMOVE, KIND_MOVE: begin
						if (stat.empty) begin
							resp_code_d = STAT_EMPTY;
						end else if (stat.pos_ge_n
							|| (stat.kind == KIND_MOVE && stat.tgt_ge_n)) begin
							resp_code_d = STAT_RANGE;
						end else begin
							state_d = S_REM_RD;
						end
					end
					KIND_DUMP: begin
						if (stat.empty) begin
							resp_code_d = STAT_EMPTY;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_DUMP_RD;
						end
					end
					KIND_REV: begin
						if (!stat.empty) begin
							cmd.addr_sel = AS_COUNT_M1;
							cmd.head_ld  = 1'b1;
							cmd.rev_flip = 1'b1;
						end
					end
					KIND_ROTL, KIND_ROTR: begin
						if (!stat.empty) begin
							state_d = S_ROT_MOD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = resp_code_q;
					cmd.emit_val    = resp_val_q;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_INS_CHK: begin
				if (stat.idx_eq_pos) begin
					cmd.addr_sel = AS_POS;
					cmd.wr_en    = 1'b1;
					cmd.cnt_inc  = 1'b1;
					resp_code_d  = STAT_OK;
					resp_val_d   = (stat.kind == KIND_MOVE) ? VAL_TAKE : VAL_ZERO;
					state_d      = S_RESP;
				end else begin
					cmd.addr_sel = AS_IDX_M1;
					cmd.rd_en    = 1'b1;
					state_d      = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.addr_sel   = AS_IDX;
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				cmd.idx_op     = IDX_DEC;
				state_d        = S_INS_CHK;
			end
			S_REM_RD: begin
				cmd.addr_sel = AS_POS;
				cmd.rd_en    = 1'b1;
				cmd.idx_op   = IDX_POS;
				state_d      = S_REM_GET;
			end
			S_REM_GET: begin
				cmd.take_cap = 1'b1;
				state_d      = S_REM_CHK;
			end
			S_REM_CHK: begin
				if (stat.idx_p1_lt_n) begin
					cmd.addr_sel = AS_IDX_P1;
					cmd.rd_en    = 1'b1;
					state_d      = S_REM_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					if (stat.kind == KIND_MOVE) begin
						state_d = S_MV_SET;
					end else begin
						resp_code_d = STAT_OK;
						resp_val_d  = VAL_TAKE;
						state_d     = S_RESP;
					end
				end
			end
			S_REM_WR: begin
				cmd.addr_sel   = AS_IDX;
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				cmd.idx_op     = IDX_INC;
				state_d        = S_REM_CHK;
			end
			S_MV_SET: begin
				cmd.mv_setup = 1'b1;
				cmd.idx_op   = IDX_COUNT;
				state_d      = S_INS_CHK;
			end
			S_DUMP_RD: begin
				cmd.addr_sel = AS_IDX;
				cmd.rd_en    = 1'b1;
				state_d      = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = STAT_OK;
					cmd.emit_val    = VAL_RD;
					cmd.emit_last   = stat.dump_last;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_DUMP_RD;
					end
				end
			end
			S_ROT_MOD: begin
				if (stat.rem_ge_n) begin
					cmd.rem_op = REM_SUB;
				end else begin
					state_d = S_ROT_ADJ;
				end
			end
			S_ROT_ADJ: begin
				if (stat.kind == KIND_ROTR && !stat.rem_zero) begin
					cmd.rem_op = REM_NEG;
				end
				state_d = S_ROT_CHK;
			end
			S_ROT_CHK: begin
				if (stat.rem_zero) begin
					resp_code_d = STAT_OK;
					resp_val_d  = VAL_ZERO;
					state_d     = S_RESP;
				end else if (stat.full) begin
					cmd.idx_op = IDX_REM;
					state_d    = S_ROT_FULL;
				end else begin
					cmd.addr_sel = AS_ZERO;
					cmd.rd_en    = 1'b1;
					state_d      = S_ROT_WR;
				end
			end
			S_ROT_FULL: begin
				cmd.addr_sel = AS_IDX;
				cmd.head_ld  = 1'b1;
				resp_code_d  = STAT_OK;
				resp_val_d   = VAL_ZERO;
				state_d      = S_RESP;
			end
			S_ROT_WR: begin
				cmd.addr_sel   = AS_COUNT;
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				state_d        = S_ROT_HD;
			end
			S_ROT_HD: begin
				cmd.addr_sel = AS_ONE;
				cmd.head_ld  = 1'b1;
				cmd.rem_op   = REM_DEC;
				state_d      = S_ROT_CHK;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/core/positional_list_engine_top.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed 32-bit values with insert, remove, move, reverse,
// rotate and dump commands, one command per input item.
// ----------------------------------------------------------------------------
// The block works on one item at a time and accepts the next item only when
// the previous one is fully handled. The list lives in a single-port-per-cycle
// memory used as a circular buffer with a head pointer and a direction flag,
// so reverse only moves the head and flips the flag, and rotating a full list
// only moves the head. The cost of an item is set by the memory, which moves
// an entry with a read and then a write: insert at position p shifts count-p
// entries, remove count-1-p, move the sum of both, dump reads and emits each
// entry (at most 64 results), and a rotation on a list that is not full moves
// entries one by one from front to back after reducing the amount modulo
// count. Errors and reverse are answered from the decode state. Results
// leave through an output register, so a waiting result stalls the block only
// when the next result is ready. There is no clearing pass after reset.
module positional_list_engine_top #(
	parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// value[31:0], position[38:32], target_position[45:39],
	// shift_amount[52:46], zero fill above.
	input  logic [55:0] s_axis_tdata,
	// kind[2:0].
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// value_out[31:0], status[33:32], zero fill above.
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import ple_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ple_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
